FILE: hdl/distinct_port_scan_detector_defines.svh
// Assertion macros for the distinct port scan detector.
// Needs clk and rst in the scope of use.
`ifndef DISTINCT_PORT_SCAN_DETECTOR_DEFINES_SVH
`define DISTINCT_PORT_SCAN_DETECTOR_DEFINES_SVH

// same-cycle implication
`define DPSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpsd assertion failed");

// next-cycle implication
`define DPSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpsd assertion failed");

`endif

FILE: hdl/dpsd_pkg.sv
// Types and constants of the distinct port scan detector.
// No dependencies.
package dpsd_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] src_address;
    logic [15:0] dest_port;
  } dpsd_in_t;

  typedef struct packed {
    logic [31:0] report_address;
    logic [6:0]  port_count;
    logic [1:0]  category;
    logic        overflowed;
    logic        last;
  } dpsd_out_t;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] CAT_NONE     = 2'd0;
  localparam logic [1:0] CAT_POSSIBLE = 2'd1;
  localparam logic [1:0] CAT_LIKELY   = 2'd2;

  localparam logic [1:0] REG_LIKELY   = 2'd0;
  localparam logic [1:0] REG_POSSIBLE = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;

  localparam logic [6:0]  LIKELY_RESET   = 7'd10;
  localparam logic [6:0]  POSSIBLE_RESET = 7'd5;
  localparam logic [15:0] LIMIT_RESET    = 16'd500;

  typedef struct packed {
    logic take_in;
    logic seen_inc;
    logic set_ovf;
    logic scan_start;
    logic scan_run;
    logic scan_port;
    logic take_hit;
    logic add_src;
    logic load_cnt;
    logic add_port;
    logic rep_start;
    logic rep_mode;
    logic rep_load;
  } dpsd_cmd_t;

  typedef struct packed {
    logic is_report;
    logic limit_hit;
    logic hit;
    logic scan_end;
    logic tbl_full;
    logic list_full;
    logic src_empty;
    logic rep_last;
    logic out_free;
  } dpsd_sts_t;

endpackage

FILE: hdl/dpsd_ctrl.sv
// Controller state machine of the distinct port scan detector.
// Depends on dpsd_pkg.
module dpsd_ctrl
  import dpsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dpsd_sts_t sts,
  output dpsd_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CHK    = 8'b0000_0010,
    ST_SSCAN  = 8'b0000_0100,
    ST_PRD    = 8'b0000_1000,
    ST_PCNT   = 8'b0001_0000,
    ST_PSCAN  = 8'b0010_0000,
    ST_REP_RD = 8'b0100_0000,
    ST_REP_WR = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (sts.is_report) begin
            if (!sts.src_empty) begin
              cmd.rep_start = 1'b1;
              state_next    = ST_REP_RD;
            end
          end else begin
            state_next = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (sts.limit_hit) begin
          cmd.set_ovf = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.seen_inc   = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SSCAN;
        end
      end
      ST_SSCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_PRD;
        end else if (sts.scan_end) begin
          if (sts.tbl_full) begin
            cmd.set_ovf = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            cmd.add_src    = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = ST_PSCAN;
          end
        end
      end
      ST_PRD: begin
        state_next = ST_PCNT;
      end
      ST_PCNT: begin
        cmd.load_cnt   = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = ST_PSCAN;
      end
      ST_PSCAN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_port = 1'b1;
        if (sts.hit) begin
          state_next = ST_IDLE;
        end else if (sts.scan_end) begin
          if (sts.list_full) begin
            cmd.set_ovf = 1'b1;
          end else begin
            cmd.add_port = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_REP_RD: begin
        cmd.rep_mode = 1'b1;
        state_next   = ST_REP_WR;
      end
      ST_REP_WR: begin
        cmd.rep_mode = 1'b1;
        if (sts.out_free) begin
          cmd.rep_load = 1'b1;
          state_next   = sts.rep_last ? ST_IDLE : ST_REP_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/dpsd_datapath.sv
// Datapath of the distinct port scan detector: tables, scan unit, config, output word.
// Depends on dpsd_pkg.
module dpsd_datapath
  import dpsd_pkg::*;
#(
  parameter int MAX_SOURCES      = 64,
  parameter int PORTS_PER_SOURCE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  dpsd_in_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output dpsd_out_t   out_word,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  dpsd_cmd_t   cmd,
  output dpsd_sts_t   sts
);

  localparam int SI_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int PI_W = (PORTS_PER_SOURCE > 1) ? $clog2(PORTS_PER_SOURCE) : 1;
  localparam int SC_W = $clog2(MAX_SOURCES + 1);
  localparam int PC_W = $clog2(PORTS_PER_SOURCE + 1);
  localparam int SN_W = (SC_W > PC_W) ? SC_W : PC_W;
  localparam int PM_DEPTH = MAX_SOURCES << PI_W;

  logic [31:0] addr_mem [MAX_SOURCES];
  logic [15:0] port_mem [PM_DEPTH];
  logic [PC_W-1:0] ppe_mem [MAX_SOURCES];

  logic [6:0]  likely_th;
  logic [6:0]  possible_th;
  logic [15:0] record_limit;
  logic [15:0] records_seen;
  logic        ovf;
  logic [SC_W-1:0] source_count;

  logic [31:0] key_addr;
  logic [15:0] key_port;
  logic [SI_W-1:0] entry;
  logic [PC_W-1:0] cnt;
  logic [SN_W-1:0] issue;
  logic [SN_W-1:0] pend_idx;
  logic            pend;
  logic [SI_W-1:0] rep_idx;

  logic [31:0] addr_q;
  logic [15:0] port_q;
  logic [PC_W-1:0] ppe_q;

  logic [SN_W-1:0] scan_lim;
  logic            issue_ok;
  logic            match;
  logic [SI_W-1:0] addr_ra;
  logic [SI_W-1:0] ppe_ra;
  logic [6:0]      cnt7;
  logic [1:0]      cat;

  always_ff @(posedge clk) begin
    if (rst) begin
      likely_th    <= LIKELY_RESET;
      possible_th  <= POSSIBLE_RESET;
      record_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIKELY:   likely_th    <= cfg_data[6:0];
        REG_POSSIBLE: possible_th  <= cfg_data[6:0];
        REG_LIMIT:    record_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign scan_lim = cmd.scan_port ? SN_W'(cnt) : SN_W'(source_count);
  assign issue_ok = issue < scan_lim;
  assign match    = cmd.scan_port ? (port_q == key_port) : (addr_q == key_addr);
  assign addr_ra  = cmd.rep_mode ? rep_idx : issue[SI_W-1:0];
  assign ppe_ra   = cmd.rep_mode ? rep_idx : entry;

  always_ff @(posedge clk) begin
    addr_q <= addr_mem[addr_ra];
    port_q <= port_mem[{entry, issue[PI_W-1:0]}];
    ppe_q  <= ppe_mem[ppe_ra];
    if (cmd.add_src) begin
      addr_mem[source_count[SI_W-1:0]] <= key_addr;
    end
    if (cmd.add_port) begin
      port_mem[{entry, cnt[PI_W-1:0]}] <= key_port;
      ppe_mem[entry] <= PC_W'(cnt + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      records_seen <= '0;
      ovf          <= 1'b0;
      source_count <= '0;
      pend         <= 1'b0;
    end else begin
      if (cmd.seen_inc) begin
        records_seen <= records_seen + 16'd1;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.add_src) begin
        source_count <= source_count + 1'b1;
      end
      if (cmd.scan_start) begin
        pend <= 1'b0;
      end else if (cmd.scan_run) begin
        pend <= issue_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      key_addr <= in_word.src_address;
      key_port <= in_word.dest_port;
    end
    if (cmd.scan_start) begin
      issue <= '0;
    end else if (cmd.scan_run && issue_ok) begin
      issue    <= issue + 1'b1;
      pend_idx <= issue;
    end
    if (cmd.take_hit) begin
      entry <= pend_idx[SI_W-1:0];
    end else if (cmd.add_src) begin
      entry <= source_count[SI_W-1:0];
    end
    if (cmd.add_src) begin
      cnt <= '0;
    end else if (cmd.load_cnt) begin
      cnt <= ppe_q;
    end
    if (cmd.rep_start) begin
      rep_idx <= '0;
    end else if (cmd.rep_load) begin
      rep_idx <= rep_idx + 1'b1;
    end
  end

  assign cnt7 = 7'(ppe_q);

  always_comb begin
    priority if (cnt7 >= likely_th) begin
      cat = CAT_LIKELY;
    end else if (cnt7 >= possible_th) begin
      cat = CAT_POSSIBLE;
    end else begin
      cat = CAT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rep_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_load) begin
      out_word.report_address <= addr_q;
      out_word.port_count     <= cnt7;
      out_word.category       <= cat;
      out_word.overflowed     <= ovf;
      out_word.last           <= sts.rep_last;
    end
  end

  assign sts.is_report = (in_word.kind == KIND_REPORT);
  assign sts.limit_hit = records_seen >= record_limit;
  assign sts.hit       = pend && match;
  assign sts.scan_end  = !pend && !issue_ok;
  assign sts.tbl_full  = source_count >= SC_W'(MAX_SOURCES);
  assign sts.list_full = cnt >= PC_W'(PORTS_PER_SOURCE);
  assign sts.src_empty = (source_count == '0);
  assign sts.rep_last  = ((SC_W'(rep_idx) + 1'b1) == source_count);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

FILE: hdl/distinct_port_scan_detector.sv
// Distinct port scan detector, top level: controller plus datapath.
// Depends on dpsd_pkg, dpsd_ctrl, dpsd_datapath and the defines header.
//
// A record word is accepted and checked against the record limit; one over the limit
// sets the overflow flag and frees the input. Otherwise the source table is scanned,
// one stored entry compared per cycle from a single registered memory read port.
// A new source is then added with its port if the table has room; a known one has
// its port count fetched and its port list scanned, and a port not yet listed is
// added if the list has room. A full table or list sets the overflow flag. A report
// word yields one result word per source, each through a memory read and the output
// register, which waits while the consumer stalls. Config writes are taken at once.
`include "distinct_port_scan_detector_defines.svh"
module distinct_port_scan_detector
  import dpsd_pkg::*;
#(
  parameter int MAX_SOURCES      = 64,
  parameter int PORTS_PER_SOURCE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  dpsd_in_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output dpsd_out_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dpsd_cmd_t cmd;
  dpsd_sts_t sts;

  assign cfg_ready = 1'b1;

  dpsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpsd_datapath #(
    .MAX_SOURCES      (MAX_SOURCES),
    .PORTS_PER_SOURCE (PORTS_PER_SOURCE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  `DPSD_ASSERT_NEXT(a_record_busy, in_valid && in_ready && (in_word.kind == KIND_RECORD), !in_ready)
  `DPSD_ASSERT_IMPL(a_add_port_room, cmd.add_port, !sts.list_full)
  `DPSD_ASSERT_IMPL(a_add_src_room, cmd.add_src, !sts.tbl_full)

endmodule
